[design/double_ended_queue_unit_macros.svh]
// assertion helpers shared by the checker
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define DEQU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DEQU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/dequ_pkg.sv]
`default_nettype none

package dequ_pkg;

  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_QUERY      = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PUT
  } state_t;

endpackage

`default_nettype wire

[design/double_ended_queue_unit.sv]
// Bounded double-ended queue of signed values held in a ring memory.
// Input channel (in_valid / in_stall, kind and value): one operation per
// transfer: push front, push back, pop front, pop back or query.
// Output channel (out_valid / out_stall): one result per operation with
// front, back, count, min, max and status after the operation.
// Config: cfg_we writes cfg_data into the reversed bit, which swaps the
// ends seen as front and back; write it only while the block is idle.
// Sequence: after the input transfer the block scans (ST_SCAN), drains the
// read pipeline (ST_DRAIN) and loads the output register (ST_PUT); it goes
// straight to ST_PUT when the queue ends up empty. The min/max scan reads
// every stored entry through the single memory read port, one per cycle,
// and in_stall stays high until the block is back in ST_IDLE.
// The next item is taken while a finished result still waits in the
// output register; a stalled result holds until out_stall falls, and a
// completed scan then waits for the output register to free up.
// Reset (rst, synchronous) empties the queue and clears the reversed bit;
// memory contents are not cleared and are read only after being written.
`default_nettype none

module double_ended_queue_unit
  import dequ_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [2:0]  kind,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      front_value,
  output logic signed [31:0]      back_value,
  output logic        [CW-1:0]    count,
  output logic signed [31:0]      min_value,
  output logic signed [31:0]      max_value,
  output logic        [1:0]       status
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_OCC  = CW'(DEPTH);

  state_t state, state_next;

  logic          reversed;
  logic [AW-1:0] first_slot, last_slot;
  logic [CW-1:0] occupancy;
  logic [1:0]    op_status;

  logic [AW-1:0] first_next, last_next;
  logic [CW-1:0] occupancy_next;
  logic [1:0]    op_status_next;

  logic                         in_xfer;
  logic                         load_out;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic signed [DATA_WIDTH-1:0] wr_data;

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] mem_q;
  logic [AW-1:0]                rd_addr;
  logic [CW-1:0]                issue_cnt;
  logic                         rd_vld, rd_first;

  logic signed [DATA_WIDTH-1:0] head_acc, tail_acc, min_acc, max_acc;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
    return (a == LAST_SLOT) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] a);
    return (a == '0) ? LAST_SLOT : a - 1'b1;
  endfunction

  // operation decode and pointer update, applied at the input transfer
  always_comb begin
    logic is_push, is_pop, at_head;
    is_push = (kind == KIND_PUSH_FRONT) || (kind == KIND_PUSH_BACK);
    is_pop  = (kind == KIND_POP_FRONT) || (kind == KIND_POP_BACK);
    at_head = is_push ? ((kind == KIND_PUSH_FRONT) != reversed)
                      : ((kind == KIND_POP_FRONT) != reversed);
    first_next     = first_slot;
    last_next      = last_slot;
    occupancy_next = occupancy;
    op_status_next = STATUS_OK;
    wr_en          = 1'b0;
    wr_addr        = first_slot;
    wr_data        = DATA_WIDTH'(value);
    if (is_push) begin
      if (occupancy == FULL_OCC) begin
        op_status_next = STATUS_FULL;
      end else begin
        wr_en          = in_xfer;
        occupancy_next = occupancy + 1'b1;
        if (occupancy == '0) begin
          last_next = first_slot;
          wr_addr   = first_slot;
        end else if (at_head) begin
          first_next = slot_dec(first_slot);
          wr_addr    = first_next;
        end else begin
          last_next = slot_inc(last_slot);
          wr_addr   = last_next;
        end
      end
    end else if (is_pop) begin
      if (occupancy == '0) begin
        op_status_next = STATUS_EMPTY;
      end else begin
        occupancy_next = occupancy - 1'b1;
        if (occupancy == CW'(1)) begin
          last_next = first_slot;
        end else if (at_head) begin
          first_next = slot_inc(first_slot);
        end else begin
          last_next = slot_dec(last_slot);
        end
      end
    end else if (occupancy == '0) begin
      op_status_next = STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    in_xfer    = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        in_xfer  = in_valid;
        if (in_valid) begin
          state_next = (occupancy_next == '0) ? ST_PUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_cnt == occupancy - 1'b1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_PUT;
      end
      ST_PUT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reversed   <= 1'b0;
      first_slot <= '0;
      last_slot  <= '0;
      occupancy  <= '0;
      rd_vld     <= 1'b0;
    end else begin
      if (cfg_we) begin
        reversed <= cfg_data;
      end
      if (in_xfer) begin
        first_slot <= first_next;
        last_slot  <= last_next;
        occupancy  <= occupancy_next;
      end
      rd_vld <= (state == ST_SCAN);
    end
  end

  // scan control: walk from the head end, one read per cycle
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_status <= op_status_next;
      rd_addr   <= first_next;
      issue_cnt <= '0;
    end else if (state == ST_SCAN) begin
      rd_addr   <= slot_inc(rd_addr);
      issue_cnt <= issue_cnt + 1'b1;
    end
    rd_first <= (issue_cnt == '0);
  end

  // ring memory; the write lands at the transfer edge, reads start in the cycle after the transfer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      tail_acc <= mem_q;
      if (rd_first) begin
        head_acc <= mem_q;
        min_acc  <= mem_q;
        max_acc  <= mem_q;
      end else begin
        if (mem_q < min_acc) begin
          min_acc <= mem_q;
        end
        if (mem_q > max_acc) begin
          max_acc <= mem_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      count  <= occupancy;
      status <= op_status;
      if (occupancy == '0) begin
        front_value <= '0;
        back_value  <= '0;
        min_value   <= '0;
        max_value   <= '0;
      end else begin
        front_value <= 32'(reversed ? tail_acc : head_acc);
        back_value  <= 32'(reversed ? head_acc : tail_acc);
        min_value   <= 32'(min_acc);
        max_value   <= 32'(max_acc);
      end
    end
  end

endmodule

`default_nettype wire

[design/dequ_checker.sv]
`default_nettype none
`include "double_ended_queue_unit_macros.svh"

module dequ_checker
  import dequ_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] front_value,
  input wire logic signed [31:0] back_value,
  input wire logic        [CW-1:0] count,
  input wire logic signed [31:0] min_value,
  input wire logic signed [31:0] max_value,
  input wire logic        [1:0]  status
);

  // stalled result transfer keeps its count, status, front and min values
  `DEQU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(count) && $stable(status) && $stable(front_value) && $stable(min_value), "stalled result changed")

  `DEQU_ASSERT_NOW(a_full_count, clk, rst, out_valid && (status == STATUS_FULL), count == CW'(DEPTH), "dropped push without full queue")

  `DEQU_ASSERT_NOW(a_empty_zero, clk, rst, out_valid && (count == '0), (front_value == 0) && (back_value == 0) && (min_value == 0) && (max_value == 0), "empty queue reports data")

  // ends must lie between the scanned extremes
  `DEQU_ASSERT_NOW(a_bounds, clk, rst, out_valid && (count != '0), (min_value <= front_value) && (front_value <= max_value) && (min_value <= back_value) && (back_value <= max_value), "front or back outside min/max")

endmodule

bind double_ended_queue_unit dequ_checker #(.DEPTH(DEPTH)) u_dequ_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .front_value (front_value),
  .back_value  (back_value),
  .count       (count),
  .min_value   (min_value),
  .max_value   (max_value),
  .status      (status)
);

`default_nettype wire

[sim/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dequ_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_COUNT = 10;
  localparam int PHASE_ITEMS = 125;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [31:0] front_v;
    logic [31:0] back_v;
    logic [4:0]  fill;
    logic [31:0] min_v;
    logic [31:0] max_v;
    logic [1:0]  status;
  } deque_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] kind = KIND_QUERY;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic [4:0] count;
  logic signed [31:0] min_value;
  logic signed [31:0] max_value;
  logic [1:0] status;

  // shadow copy of the queue, head end first
  logic [31:0] shadow_deque[$];
  bit shadow_reversed = 1'b0;
  deque_view_t expected_views[$];
  int mismatch_count = 0;

  // sender pacing
  bit gapless = 1'b0;
  int quiet_items = 0;

  // receiver pacing; hold requests come from the test sequence
  int hold_seq = 0;
  int hold_len = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  int calm_left = 0;
  int idle_cycles = 0;

  double_ended_queue_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .front_value(front_value),
    .back_value (back_value),
    .count      (count),
    .min_value  (min_value),
    .max_value  (max_value),
    .status     (status)
  );

  always #10 clk = ~clk;

  function automatic deque_view_t apply_deque_op(input logic [2:0] op, input logic [31:0] data);
    deque_view_t v;
    logic [31:0] head_v;
    logic [31:0] tail_v;
    int i;
    v = '0;
    v.status = STATUS_OK;
    case (op)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (shadow_deque.size() >= QUEUE_DEPTH) begin
          v.status = STATUS_FULL;
        end else if ((op == KIND_PUSH_FRONT) != shadow_reversed) begin
          shadow_deque.push_front(data);
        end else begin
          shadow_deque.push_back(data);
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (shadow_deque.size() == 0) begin
          v.status = STATUS_EMPTY;
        end else if ((op == KIND_POP_FRONT) != shadow_reversed) begin
          void'(shadow_deque.pop_front());
        end else begin
          void'(shadow_deque.pop_back());
        end
      end
      // query and the spare codes
      default: begin
        if (shadow_deque.size() == 0) v.status = STATUS_EMPTY;
      end
    endcase
    v.fill = 5'(shadow_deque.size());
    if (shadow_deque.size() != 0) begin
      head_v = shadow_deque[0];
      tail_v = shadow_deque[shadow_deque.size() - 1];
      v.min_v = head_v;
      v.max_v = head_v;
      for (i = 1; i < shadow_deque.size(); i++) begin
        if ($signed(shadow_deque[i]) < $signed(v.min_v)) v.min_v = shadow_deque[i];
        if ($signed(shadow_deque[i]) > $signed(v.max_v)) v.max_v = shadow_deque[i];
      end
      v.front_v = shadow_reversed ? tail_v : head_v;
      v.back_v = shadow_reversed ? head_v : tail_v;
    end
    return v;
  endfunction

  function automatic int pick_stretch();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int next_send_gap();
    int r;
    if (gapless) return 0;
    if (quiet_items > 0) begin
      quiet_items--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      quiet_items = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    return pick_stretch();
  endfunction

  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h8000_0000;
    if (r == 1) return 32'h7FFF_FFFF;
    if (r == 2) return $urandom_range(0, 8) - 4;
    return $urandom;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, $signed(want), $signed(got));
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    deque_view_t want;
    if (expected_views.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual count %0d status %0d",
               $time, count, status);
      mismatch_count++;
    end else begin
      want = expected_views.pop_front();
      compare_field("front_value", want.front_v, front_value);
      compare_field("back_value", want.back_v, back_value);
      compare_field("count", 32'(want.fill), 32'(count));
      compare_field("min_value", want.min_v, min_value);
      compare_field("max_value", want.max_v, max_value);
      compare_field("status", 32'(want.status), 32'(status));
    end
  endtask

  // result checking and output-side stall pattern
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result();
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0: begin
          calm_left = $urandom_range(20, 80);
          out_stall <= 1'b0;
        end
        1, 2, 3: begin
          stall_left = pick_stretch() - 1;
          out_stall <= 1'b1;
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("** double_ended_queue_unit: FAILED **");
      $finish;
    end
  end

  // valid stays up when the next operation follows with no gap
  task automatic send_op(input logic [2:0] op, input logic [31:0] data);
    int gap;
    gap = next_send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= op;
    value <= data;
    do @(posedge clk); while (in_stall);
    expected_views.push_back(apply_deque_op(op, data));
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reversed(input bit rev);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= rev;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_reversed = rev;
  endtask

  task automatic random_op(input int bias);
    int r;
    int push_pct;
    int pop_pct;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    push_pct = (bias == 0) ? 70 : (bias == 1) ? 25 : 45;
    pop_pct = (bias == 0) ? 20 : (bias == 1) ? 65 : 45;
    if (r < push_pct) begin
      op = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
    end else if (r < push_pct + pop_pct) begin
      op = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
    end else if ($urandom_range(0, 1)) begin
      op = KIND_QUERY;
    end else begin
      op = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    end
    send_op(op, rand_value());
  endtask

  task automatic test_empty_and_extremes();
    send_op(KIND_QUERY, 32'h0);
    send_op(KIND_POP_FRONT, 32'hFFFF_FFFF);
    send_op(KIND_POP_BACK, 32'h1234_5678);
    send_op(KIND_SPARE_HI, 32'h0);
    // first push lands in an empty queue
    send_op(KIND_PUSH_BACK, 32'h7FFF_FFFF);
    send_op(KIND_PUSH_FRONT, 32'h8000_0000);
    send_op(KIND_SPARE_LO, 32'h5555_5555);
    send_op(KIND_POP_BACK, 32'h0);
    send_op(KIND_POP_FRONT, 32'h0);
    send_op(KIND_PUSH_FRONT, 32'hFFFF_FFFF);
    drain_outputs();
  endtask

  task automatic test_fill_and_overflow();
    int i;
    for (i = 1; i < QUEUE_DEPTH; i++) begin
      send_op((i % 2) ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
              (i % 2) ? -(i * 1000) : i * 7);
    end
    // queue now full: both pushes get dropped
    send_op(KIND_PUSH_FRONT, 32'h8000_0000);
    send_op(KIND_PUSH_BACK, 32'h7FFF_FFFF);
    send_op(KIND_QUERY, 32'hAAAA_AAAA);
    drain_outputs();
  endtask

  task automatic test_long_output_stall();
    int i;
    hold_len = HOLD_CYCLES;
    hold_seq++;
    gapless = 1'b1;
    for (i = 0; i < 40; i++) random_op(2);
    gapless = 1'b0;
    drain_outputs();
  endtask

  task automatic test_random_traffic();
    int p;
    int i;
    for (p = 0; p < PHASE_COUNT; p++) begin
      if (p > 0) begin
        drain_outputs();
        write_reversed((p % 2) != 0);
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // in phases with p % 3 == 1 the sender waits for every outstanding result mid-phase
        if (i == PHASE_ITEMS / 2 && p % 3 == 1) drain_outputs();
        random_op(p % 3);
      end
    end
    drain_outputs();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_reversed(1'b0);
    test_empty_and_extremes();
    test_fill_and_overflow();
    test_long_output_stall();
    test_random_traffic();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** double_ended_queue_unit: PASSED **");
    end else begin
      $display("** double_ended_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
